### src/rect_fill_blend_engine_defines.svh
// Assertion macros for the blitter
`ifndef RECT_FILL_BLEND_ENGINE_DEFINES_SVH
`define RECT_FILL_BLEND_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define RFB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RFB_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define RFB_ASSERT(label, clk, rst_n, prop)
`define RFB_ASSERT_RST(label, clk, prop)
`endif
`endif

### src/rfb_pkg.sv
package rfb_pkg;
  localparam logic [2:0] CMD_FILL     = 3'd0;
  localparam logic [2:0] CMD_BLEND    = 3'd1;
  localparam logic [2:0] CMD_GRADIENT = 3'd2;
  localparam logic [2:0] CMD_SCAN     = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SETUP, ST_ROW, ST_TDIV, ST_GCOL, ST_PRD, ST_PWAIT,
    ST_PMUL, ST_PDIV, ST_PWR, ST_NEXT, ST_RD, ST_RWAIT, ST_DONE
  } state_e;

  // Divider control between sequencer and shared divider
  typedef struct packed {
    logic        start;
    logic [18:0] num;
    logic [11:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [18:0] quo;
  } div_rsp_t;
endpackage

### src/rect_fill_blend_engine.sv
// Rectangle fill / blend blitter over an internal RGB888 framebuffer.
// Command channel: start with command fields is taken when busy is low;
// busy stays high until the result strobe. One result per command:
// valid_o pulses for one cycle with pixel_o and in_bounds_o. The receiver
// cannot stall; results must be captured on the strobe.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; write only while idle. Index 0 is active width, 1 height.
// After reset a clearing pass writes black over all MAX_WIDTH*MAX_HEIGHT
// entries, one per cycle; commands are held off (busy high) meanwhile.
// Every command passes through a setup state after acceptance and a
// strobe state at the end; busy drops the cycle after the strobe.
// Fill: each clipped pixel is written, then the position advances. Blend
// fill and scanlines, per pixel: read, wait, then product and
// divide-by-255 per channel, write, advance. Gradient: each drawn row
// forms its row weight on the shared divider when the height exceeds
// one, then the row colour, then writes the row's pixels; rows off the
// surface are stepped over. Pixel read: setup, read, wait, then strobe.
// Empty rectangles and ignored commands pass from setup to the strobe.
module rect_fill_blend_engine #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   command_i,
  input  logic [11:0]  pos_x_i,
  input  logic [11:0]  pos_y_i,
  input  logic [11:0]  rect_width_i,
  input  logic [11:0]  rect_height_i,
  input  logic [23:0]  color_i,
  input  logic [23:0]  second_color_i,
  input  logic [7:0]   alpha_i,
  output logic         valid_o,
  output logic [23:0]  pixel_o,
  output logic         in_bounds_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [8:0]   cfg_data_i
);
  `include "rect_fill_blend_engine_defines.svh"

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  rfb_pkg::state_e state_q, state_d;

  logic [8:0]  aw_q, ah_q;
  logic [12:0] effw, effh;
  logic [2:0]  cmd_q;
  logic signed [13:0] x_q, y_q, w_q, h_q;
  logic [23:0] c_q, c2_q, gc_q;
  logic [7:0]  a_q, t_q;
  logic [12:0] x0_q, x1_q, y1_q;
  logic [12:0] row_q, col_q;
  logic [11:0] j_q;
  logic [23:0] pix_q, acc_q;
  logic [1:0]  ch_q;
  logic [AW:0] clr_q;
  logic [23:0] res_pix_q;
  logic        res_inb_q;

  // Saturate the configured size to the supported range
  always_comb begin
    effw = (aw_q == 9'd0) ? 13'd1 : {4'd0, aw_q};
    if (effw > 13'(MAX_WIDTH)) effw = 13'(MAX_WIDTH);
    effh = (ah_q == 9'd0) ? 13'd1 : {4'd0, ah_q};
    if (effh > 13'(MAX_HEIGHT)) effh = 13'(MAX_HEIGHT);
  end

  // Clipped bounds computed from latched command
  logic signed [14:0] cx0, cy0, cx1, cy1;
  always_comb begin
    cx0 = (x_q < 0) ? 15'sd0 : 15'(x_q);
    cy0 = (y_q < 0) ? 15'sd0 : 15'(y_q);
    cx1 = 15'(x_q) + 15'(w_q);
    if (cx1 > $signed({2'b0, effw})) cx1 = $signed({2'b0, effw});
    cy1 = 15'(y_q) + 15'(h_q);
    if (cy1 > $signed({2'b0, effh})) cy1 = $signed({2'b0, effh});
  end

  // Shared divider
  rfb_pkg::div_req_t dreq;
  rfb_pkg::div_rsp_t drsp;
  rfb_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Blend product for the current channel
  logic [7:0]  ca, cb, wt;
  logic [16:0] prod;
  always_comb begin
    if (cmd_q == rfb_pkg::CMD_GRADIENT) begin
      ca = c_q[8*ch_q +: 8]; cb = c2_q[8*ch_q +: 8];
    end else if (cmd_q == rfb_pkg::CMD_BLEND) begin
      ca = pix_q[8*ch_q +: 8]; cb = c_q[8*ch_q +: 8];
    end else begin
      ca = pix_q[8*ch_q +: 8]; cb = 8'd0;
    end
    wt = (cmd_q == rfb_pkg::CMD_GRADIENT) ? t_q : a_q;
    prod = 17'(ca) * 17'(8'd255 - wt) + 17'(cb) * 17'(wt);
  end

  // Divide the held product by 255, exact for products up to 255*255
  logic [16:0] prod_q, qsum;
  logic [7:0]  quo255;
  assign qsum   = prod_q + 17'd1 + 17'(prod_q[16:8]);
  assign quo255 = qsum[15:8];

  // Memory port
  logic          we;
  logic [AW-1:0] addr;
  logic [23:0]   wdata, rdata;
  logic [25:0]   lin;
  assign lin = 26'(row_q) * 26'(effw) + 26'(col_q);
  rfb_mem #(.AW(AW)) u_mem (.clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata),
                            .rdata_o(rdata));

  // Scanlines step two rows and must stop past the last odd row
  logic last_col, last_row;
  assign last_col = (col_q + 13'd1 >= x1_q);
  assign last_row = (cmd_q == rfb_pkg::CMD_SCAN) ? (row_q + 13'd2 >= y1_q)
                                                 : (row_q + 13'd1 >= y1_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rfb_pkg::ST_CLEAR: if (clr_q == (AW+1)'(DEPTH - 1)) state_d = rfb_pkg::ST_IDLE;
      rfb_pkg::ST_IDLE:  if (start) state_d = rfb_pkg::ST_SETUP;
      rfb_pkg::ST_SETUP: begin
        if (cmd_q == rfb_pkg::CMD_READ) state_d = rfb_pkg::ST_RD;
        else if (cmd_q == rfb_pkg::CMD_SCAN)
          state_d = (effh > 13'd1) ? rfb_pkg::ST_PRD : rfb_pkg::ST_DONE;
        else if (cmd_q == rfb_pkg::CMD_GRADIENT)
          state_d = (h_q > 0 && w_q > 0 && cx1 > cx0) ? rfb_pkg::ST_ROW
                                                       : rfb_pkg::ST_DONE;
        else if (cmd_q == rfb_pkg::CMD_FILL || cmd_q == rfb_pkg::CMD_BLEND)
          state_d = (w_q > 0 && h_q > 0 && cx1 > cx0 && cy1 > cy0)
                    ? ((cmd_q == rfb_pkg::CMD_FILL) ? rfb_pkg::ST_PWR : rfb_pkg::ST_PRD)
                    : rfb_pkg::ST_DONE;
        else state_d = rfb_pkg::ST_DONE;
      end
      rfb_pkg::ST_ROW: begin
        if ($signed({1'b0, j_q}) >= h_q[12:0]) state_d = rfb_pkg::ST_DONE;
        else if (y_q + $signed({2'b0, j_q}) < 0 ||
                 y_q + $signed({2'b0, j_q}) >= $signed({1'b0, effh}))
          state_d = rfb_pkg::ST_ROW;
        else state_d = (h_q > 1) ? rfb_pkg::ST_TDIV : rfb_pkg::ST_PMUL;
      end
      rfb_pkg::ST_TDIV:  if (drsp.done) state_d = rfb_pkg::ST_PMUL;
      rfb_pkg::ST_PRD:   state_d = rfb_pkg::ST_PWAIT;
      rfb_pkg::ST_PWAIT: state_d = rfb_pkg::ST_PMUL;
      rfb_pkg::ST_PMUL:  state_d = rfb_pkg::ST_PDIV;
      rfb_pkg::ST_PDIV:
        state_d = (ch_q == 2'd2) ?
          ((cmd_q == rfb_pkg::CMD_GRADIENT) ? rfb_pkg::ST_GCOL : rfb_pkg::ST_PWR)
          : rfb_pkg::ST_PMUL;
      rfb_pkg::ST_GCOL:  state_d = last_col ? rfb_pkg::ST_ROW : rfb_pkg::ST_GCOL;
      rfb_pkg::ST_PWR:   state_d = rfb_pkg::ST_NEXT;
      rfb_pkg::ST_NEXT:
        if (last_col && last_row) state_d = rfb_pkg::ST_DONE;
        else state_d = (cmd_q == rfb_pkg::CMD_FILL) ? rfb_pkg::ST_PWR : rfb_pkg::ST_PRD;
      rfb_pkg::ST_RD:    state_d = rfb_pkg::ST_RWAIT;
      rfb_pkg::ST_RWAIT: state_d = rfb_pkg::ST_DONE;
      rfb_pkg::ST_DONE:  state_d = rfb_pkg::ST_IDLE;
      default:           state_d = rfb_pkg::ST_IDLE;
    endcase
  end

  logic rd_ok;
  assign rd_ok = (x_q >= 0) && (x_q < $signed({1'b0, effw})) &&
                 (y_q >= 0) && (y_q < $signed({1'b0, effh}));

  // Outputs of the sequencer
  always_comb begin
    we = 1'b0; wdata = 24'd0; addr = lin[AW-1:0];
    dreq.start = 1'b0; dreq.num = '0; dreq.den = 12'd1;
    if (state_q == rfb_pkg::ST_CLEAR) begin
      we = 1'b1; addr = clr_q[AW-1:0];
    end
    if (state_q == rfb_pkg::ST_PWR) begin
      we = (lin < 26'(DEPTH)); wdata = (cmd_q == rfb_pkg::CMD_FILL) ? c_q : acc_q;
    end
    if (state_q == rfb_pkg::ST_GCOL) begin
      we = (lin < 26'(DEPTH)); wdata = gc_q;
    end
    if (state_q == rfb_pkg::ST_ROW) begin
      dreq.start = 1'b1; dreq.num = 19'(j_q) * 19'd255; dreq.den = h_q[11:0] - 12'd1;
    end
  end

  assign busy        = (state_q != rfb_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == rfb_pkg::ST_IDLE);
  assign valid_o     = (state_q == rfb_pkg::ST_DONE);
  assign pixel_o     = res_pix_q;
  assign in_bounds_o = res_inb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfb_pkg::ST_CLEAR; clr_q <= '0;
      aw_q <= 9'd256; ah_q <= 9'd256;
    end else begin
      state_q <= state_d;
      if (state_q == rfb_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == rfb_pkg::CFG_WIDTH) aw_q <= cfg_data_i;
        else ah_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      rfb_pkg::ST_IDLE: if (start) begin
        cmd_q <= command_i;
        x_q <= 14'($signed(pos_x_i)); y_q <= 14'($signed(pos_y_i));
        w_q <= 14'($signed(rect_width_i)); h_q <= 14'($signed(rect_height_i));
        c_q <= color_i; c2_q <= second_color_i; a_q <= alpha_i;
        res_pix_q <= 24'd0; res_inb_q <= 1'b0;
      end
      rfb_pkg::ST_SETUP: begin
        j_q <= '0; ch_q <= 2'd0; acc_q <= '0;
        if (cmd_q == rfb_pkg::CMD_SCAN) begin
          x0_q <= 13'd0; x1_q <= effw; y1_q <= effh; col_q <= 13'd0; row_q <= 13'd1;
        end else if (cmd_q == rfb_pkg::CMD_READ) begin
          col_q <= x_q[12:0]; row_q <= y_q[12:0];
        end else begin
          x0_q <= cx0[12:0]; x1_q <= cx1[12:0]; y1_q <= cy1[12:0];
          col_q <= cx0[12:0]; row_q <= cy0[12:0];
        end
      end
      rfb_pkg::ST_ROW: begin
        t_q <= 8'd0; ch_q <= 2'd0;
        row_q <= 13'(y_q + $signed({2'b0, j_q}));
        col_q <= x0_q;
        if (state_d == rfb_pkg::ST_ROW) j_q <= j_q + 12'd1;
      end
      rfb_pkg::ST_TDIV: if (drsp.done) t_q <= drsp.quo[7:0];
      rfb_pkg::ST_PWAIT: begin
        pix_q <= rdata; ch_q <= 2'd0;
      end
      rfb_pkg::ST_PMUL: prod_q <= prod;
      rfb_pkg::ST_PDIV: begin
        acc_q[8*ch_q +: 8] <= quo255;
        if (ch_q == 2'd2) gc_q <= {quo255, acc_q[15:0]};
        ch_q <= ch_q + 2'd1;
      end
      rfb_pkg::ST_GCOL: begin
        col_q <= col_q + 13'd1;
        if (last_col) j_q <= j_q + 12'd1;
      end
      rfb_pkg::ST_NEXT: begin
        if (last_col) begin
          col_q <= x0_q;
          row_q <= row_q + ((cmd_q == rfb_pkg::CMD_SCAN) ? 13'd2 : 13'd1);
        end else col_q <= col_q + 13'd1;
      end
      rfb_pkg::ST_RWAIT: begin
        res_inb_q <= rd_ok;
        res_pix_q <= (rd_ok && lin < 26'(DEPTH)) ? rdata : 24'd0;
      end
      default: ;
    endcase
  end

  `RFB_ASSERT(a_busy_valid, clk_i, rst_ni, valid_o |-> busy)
  `RFB_ASSERT(a_done_idle, clk_i, rst_ni, valid_o |=> !busy)
  `RFB_ASSERT(a_no_cfg_busy, clk_i, rst_ni, busy |-> !cfg_ready_o)
  `RFB_ASSERT(a_no_we_read, clk_i, rst_ni, (state_q == rfb_pkg::ST_RD || state_q == rfb_pkg::ST_RWAIT) |-> !we)
endmodule

### src/rfb_div.sv
// Restoring divider, one quotient bit per cycle
module rfb_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfb_pkg::div_req_t req_i,
  output rfb_pkg::div_rsp_t rsp_o
);
  logic [18:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [12:0] trial;

  assign trial = {rem_q[11:0], quo_q[18]};

  // Shift in one numerator bit per step
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den; cnt_d = 5'd19; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q}; quo_d = {quo_q[17:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[17:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

### src/rfb_mem.sv
// Framebuffer storage, one port, registered read
module rfb_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [23:0]   wdata_i,
  output logic [23:0]   rdata_o
);
  logic [23:0] mem [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FB_WIDTH  = 256;
  localparam int unsigned FB_HEIGHT = 256;
  localparam int unsigned FB_DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_LEN = 70;
  // first of the codes that the block ignores
  localparam logic [2:0]  CMD_UNKNOWN = rfb_pkg::CMD_READ + 3'd1;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] w;
    logic signed [11:0] h;
    logic [23:0]        colour;
    logic [23:0]        colour2;
    logic [7:0]         alpha;
  } draw_req_t;

  typedef struct {
    logic [23:0] pixel;
    logic        in_bounds;
  } read_back_t;

  // Surface model: framebuffer image, size registers and pending read-backs
  class scoreboard;
    logic [23:0] image [FB_DEPTH];
    logic [8:0]  width_reg  = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    read_back_t  read_backs [$];
    int          mismatches = 0;

    function new();
      foreach (image[k]) image[k] = 24'h000000;
    endfunction

    function int surf_w();
      return (width_reg == 0) ? 1 : ((width_reg > FB_WIDTH) ? FB_WIDTH : int'(width_reg));
    endfunction

    function int surf_h();
      return (height_reg == 0) ? 1 : ((height_reg > FB_HEIGHT) ? FB_HEIGHT : int'(height_reg));
    endfunction

    function void set_reg(logic idx, logic [8:0] val);
      if (idx == rfb_pkg::CFG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function logic [23:0] mix(logic [23:0] a, logic [23:0] b, int t);
      logic [23:0] r;
      int ca, cb;
      for (int k = 0; k < 3; k++) begin
        ca = a[8*k +: 8];
        cb = b[8*k +: 8];
        r[8*k +: 8] = 8'((ca * (255 - t) + cb * t) / 255);
      end
      return r;
    endfunction

    // clip to the surface, then write or blend each pixel
    function void paint(int x, int y, int w, int h, logic [23:0] c, int t, bit over);
      int sw, sh, idx;
      sw = surf_w();
      sh = surf_h();
      if (x < 0) begin w += x; x = 0; end
      if (y < 0) begin h += y; y = 0; end
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
      for (int j = 0; j < h; j++)
        for (int i = 0; i < w; i++) begin
          idx = (y + j) * sw + x + i;
          if (idx < FB_DEPTH) image[idx] = over ? mix(image[idx], c, t) : c;
        end
    endfunction

    function void note_request(draw_req_t r);
      read_back_t rb;
      int sw, sh, x, y, w, h, t;
      sw = surf_w();
      sh = surf_h();
      x = r.x;
      y = r.y;
      w = r.w;
      h = r.h;
      rb.pixel = 24'h000000;
      rb.in_bounds = 1'b0;
      case (r.cmd)
        rfb_pkg::CMD_FILL:  paint(x, y, w, h, r.colour, 0, 1'b0);
        rfb_pkg::CMD_BLEND: paint(x, y, w, h, r.colour, r.alpha, 1'b1);
        rfb_pkg::CMD_GRADIENT: begin
          // rows off the surface still advance the weight
          for (int j = 0; j < h; j++) begin
            t = (h > 1) ? (j * 255 / (h - 1)) : 0;
            if (y + j >= 0 && y + j < sh)
              paint(x, y + j, w, 1, mix(r.colour, r.colour2, t & 255), 0, 1'b0);
          end
        end
        rfb_pkg::CMD_SCAN: begin
          for (int j = 1; j < sh; j += 2)
            for (int i = 0; i < sw; i++)
              image[j * sw + i] = mix(image[j * sw + i], 24'h000000, r.alpha);
        end
        rfb_pkg::CMD_READ: begin
          if (x >= 0 && x < sw && y >= 0 && y < sh) begin
            rb.pixel = image[y * sw + x];
            rb.in_bounds = 1'b1;
          end
        end
        default: ;
      endcase
      read_backs.push_back(rb);
    endfunction

    function void check_result(logic [23:0] pixel, logic in_bounds);
      read_back_t rb;
      if (read_backs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pixel=%06h in_bounds=%0b",
                                       pixel, in_bounds);
        return;
      end
      rb = read_backs.pop_front();
      if (pixel !== rb.pixel || in_bounds !== rb.in_bounds) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected pixel=%06h in_bounds=%0b, got pixel=%06h in_bounds=%0b",
                   rb.pixel, rb.in_bounds, pixel, in_bounds);
      end
    endfunction

    function int pending();
      return read_backs.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  command_i;
  logic [11:0] pos_x_i;
  logic [11:0] pos_y_i;
  logic [11:0] rect_width_i;
  logic [11:0] rect_height_i;
  logic [23:0] color_i;
  logic [23:0] second_color_i;
  logic [7:0]  alpha_i;
  logic        valid_o;
  logic [23:0] pixel_o;
  logic        in_bounds_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [8:0]  cfg_data_i;

  scoreboard sb = new();
  bit        idling;

  rect_fill_blend_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .color_i        (color_i),
    .second_color_i (second_color_i),
    .alpha_i        (alpha_i),
    .valid_o        (valid_o),
    .pixel_o        (pixel_o),
    .in_bounds_o    (in_bounds_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Capture each result strobe
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(pixel_o, in_bounds_o);
  end

  // Issue one request; optionally preceded by an idle burst
  task automatic send_request(draw_req_t r);
    if (idling && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= r.cmd;
    pos_x_i        <= r.x;
    pos_y_i        <= r.y;
    rect_width_i   <= r.w;
    rect_height_i  <= r.h;
    color_i        <= r.colour;
    second_color_i <= r.colour2;
    alpha_i        <= r.alpha;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  task automatic send(logic [2:0] cmd, int x, int y, int w, int h,
                      logic [23:0] c, logic [23:0] c2, logic [7:0] a);
    draw_req_t r;
    r.cmd = cmd;
    r.x = 12'(x);
    r.y = 12'(y);
    r.w = 12'(w);
    r.h = 12'(h);
    r.colour = c;
    r.colour2 = c2;
    r.alpha = a;
    send_request(r);
  endtask

  // Hold off until every result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Random request over a small surface; some are full-range noise
  function automatic draw_req_t make_request();
    draw_req_t r;
    int sw, sh, sel;
    sw = sb.surf_w();
    sh = sb.surf_h();
    sel = $urandom_range(0, 99);
    if (sel < 30)      r.cmd = rfb_pkg::CMD_READ;
    else if (sel < 50) r.cmd = rfb_pkg::CMD_FILL;
    else if (sel < 68) r.cmd = rfb_pkg::CMD_BLEND;
    else if (sel < 84) r.cmd = rfb_pkg::CMD_GRADIENT;
    else if (sel < 95) r.cmd = rfb_pkg::CMD_SCAN;
    else               r.cmd = 3'($urandom_range(CMD_UNKNOWN, 7));
    r.colour  = 24'($urandom);
    r.colour2 = 24'($urandom);
    r.alpha   = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                            : 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      r.x = 12'($urandom);
      r.y = 12'($urandom);
      r.w = 12'($urandom);
      r.h = 12'($urandom);
      // keep gradients short: every drawn row costs divider time
      if (r.cmd == rfb_pkg::CMD_GRADIENT && r.h > 40) r.h = r.h % 41;
    end else begin
      r.x = 12'($urandom_range(0, sw + 6) - 4);
      r.y = 12'($urandom_range(0, sh + 6) - 4);
      r.w = 12'($urandom_range(0, sw + 6) - 2);
      r.h = 12'($urandom_range(0, sh + 6) - 2);
    end
    return r;
  endfunction

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    command_i      <= rfb_pkg::CMD_FILL;
    pos_x_i        <= '0;
    pos_y_i        <= '0;
    rect_width_i   <= '0;
    rect_height_i  <= '0;
    color_i        <= '0;
    second_color_i <= '0;
    alpha_i        <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= rfb_pkg::CFG_WIDTH;
    cfg_data_i     <= '0;
    idling         = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full surface: corners, clipping, empty rectangles, blend weights, gradients, ignored codes
    send(rfb_pkg::CMD_READ, 0, 0, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 255, 255, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, -1, 0, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 256, 0, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_FILL, -1, -1, 3, 3, 24'hFFFFFF, 24'h0, 8'h0);
    send(rfb_pkg::CMD_FILL, 253, 254, 100, 100, 24'h123456, 24'h0, 8'h0);
    send(rfb_pkg::CMD_FILL, 4, 4, 0, 5, 24'hABCDEF, 24'h0, 8'h0);
    send(rfb_pkg::CMD_FILL, 4, 4, 5, -3, 24'hABCDEF, 24'h0, 8'h0);
    send(rfb_pkg::CMD_FILL, 300, 2, 4, 4, 24'hABCDEF, 24'h0, 8'h0);
    send(rfb_pkg::CMD_BLEND, 0, 0, 2, 1, 24'h00FF80, 24'h0, 8'h00);
    send(rfb_pkg::CMD_BLEND, 1, 1, 1, 1, 24'h00FF80, 24'h0, 8'hFF);
    send(rfb_pkg::CMD_BLEND, 0, 1, 1, 1, 24'h804020, 24'h0, 8'h80);
    send(rfb_pkg::CMD_GRADIENT, 10, 10, 3, 1, 24'hFF0000, 24'h0000FF, 8'h0);
    send(rfb_pkg::CMD_GRADIENT, 20, -2, 2, 6, 24'hFF00FF, 24'h00FF00, 8'h0);
    send(rfb_pkg::CMD_READ, 1, 1, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 0, 1, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 255, 255, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 21, 3, 0, 0, 24'h0, 24'h0, 8'h0);
    for (int k = CMD_UNKNOWN; k <= 7; k++) send(3'(k), 0, 0, 1, 1, 24'hFFFFFF, 24'h0, 8'h0);
    drain();

    // Zero registers act as a one-pixel surface
    write_reg(rfb_pkg::CFG_WIDTH, 9'd0);
    write_reg(rfb_pkg::CFG_HEIGHT, 9'd0);
    send(rfb_pkg::CMD_SCAN, 0, 0, 0, 0, 24'h0, 24'h0, 8'hFF);
    send(rfb_pkg::CMD_READ, 0, 0, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 1, 0, 0, 0, 24'h0, 24'h0, 8'h0);
    drain();

    // Oversized registers saturate; old contents read through new addressing
    write_reg(rfb_pkg::CFG_WIDTH, 9'h1FF);
    write_reg(rfb_pkg::CFG_HEIGHT, 9'h1FF);
    send(rfb_pkg::CMD_READ, 255, 255, 0, 0, 24'h0, 24'h0, 8'h0);
    send(rfb_pkg::CMD_READ, 0, 256, 0, 0, 24'h0, 24'h0, 8'h0);
    drain();

    // Random phases on small surfaces; every third one and the last run without gaps
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(rfb_pkg::CFG_WIDTH,
                (p == 0) ? 9'd1 : (p == 1) ? 9'd12 : 9'($urandom_range(1, 12)));
      write_reg(rfb_pkg::CFG_HEIGHT,
                (p == 0) ? 9'd12 : (p == 1) ? 9'd1 : 9'($urandom_range(1, 12)));
      idling = (p != N_PHASES - 1) && (p % 3 != 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_request(make_request());
        if ($urandom_range(0, 40) == 0) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/rfb_pkg.sv
src/rfb_div.sv
src/rfb_mem.sv
src/rect_fill_blend_engine.sv
dv/testbench.sv
